@@ rtl/tdfm_pkg.sv @@
// Package for the tile deduplication block: sizes, register map, states and helpers.
// No dependencies.
package tdfm_pkg;

   localparam int MaxTiles = 2048;
   localparam int Rows = 8;
   localparam int RowW = 32;
   localparam int TileIdxW = $clog2(MaxTiles);
   localparam int CountW = TileIdxW + 1;
   localparam int StoreDepth = MaxTiles * Rows;
   localparam int StoreAddrW = $clog2(StoreDepth);
   localparam int OutIdxW = 11;
   localparam int CsrAddrW = 1;
   localparam logic [CsrAddrW-1:0] RegFlipDisable = 1'b0;

   typedef enum logic [2:0] {
      ST_GATHER,
      ST_READ,
      ST_CMP,
      ST_WRITE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [OutIdxW-1:0] tile_index;
      logic hflip;
      logic vflip;
      logic new_tile;
      logic [1:0] tile_palette;
      logic store_full;
   } result_type;

   function automatic logic [RowW-1:0] mirror_row(input logic [RowW-1:0] r);
      logic [RowW-1:0] o;
      for (int k = 0; k < 8; k++) begin
         o[k*4 +: 4] = r[(7-k)*4 +: 4];
      end
      return o;
   endfunction

endpackage

@@ rtl/tile_dedup_flip_match.sv @@
// Tile deduplication with flip matching: gathers an 8x8 tile of 4-bit pixels, one row per
// transfer, then searches the stored tiles in insertion order, unflipped, h, v and both
// mirrored (unflipped only if flips are disabled), returning the first hit or appending the
// tile, or flagging store_full if the store is full. The eighth row starts a search that reads
// the single-port tile memory a row at a time, a read state then a compare state per row; with
// an empty store the tile is appended without a search. Reset clears the tile count; memory
// needs no clearing pass. Depends on tdfm_pkg and tdfm_engine.
module tile_dedup_flip_match (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // row_pixels[31:0]
   input  logic [1:0]  req_tuser,   // palette_line[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // tile_index[10:0], hflip, vflip, new_tile, tile_palette[1:0]
   output logic        rsp_tuser,   // store_full
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [tdfm_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tdfm_pkg::*;

   logic flip_disable_ff;
   result_type res;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegFlipDisable) ? {31'd0, flip_disable_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_disable_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == RegFlipDisable) begin
         flip_disable_ff <= csr_pwdata[0];
      end
   end

   tdfm_engine u_engine (
      .clock(clock), .reset(reset), .flip_disable(flip_disable_ff),
      .row_valid(req_tvalid), .row_ready(req_tready),
      .row_pixels(req_tdata), .palette_line(req_tuser),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res(res)
   );

   assign rsp_tdata = {res.tile_palette, res.new_tile, res.vflip, res.hflip, res.tile_index};
   assign rsp_tuser = res.store_full;
endmodule

@@ rtl/tdfm_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module tdfm_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

@@ rtl/tdfm_engine.sv @@
// Search engine: gathers rows, compares against the tile store in four orientations (one when flips are disabled).
// Depends on tdfm_pkg and tdfm_ram.
module tdfm_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       flip_disable,
   input  logic                       row_valid,
   output logic                       row_ready,
   input  logic [tdfm_pkg::RowW-1:0]  row_pixels,
   input  logic [1:0]                 palette_line,
   output logic                       res_valid,
   input  logic                       res_ready,
   output tdfm_pkg::result_type       res
);
   import tdfm_pkg::*;

   state_type state_ff, state_in;
   logic [RowW-1:0] rows_ff [Rows];
   logic [2:0] rowcnt_ff, rowcnt_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [TileIdxW-1:0] tile_ff, tile_in;
   logic [1:0] orient_ff, orient_in;
   logic [2:0] r_ff, r_in;
   logic ok_ff, ok_in;
   logic [1:0] pal_ff;
   result_type res_ff, res_in;

   logic we;
   logic [StoreAddrW-1:0] addr;
   logic [RowW-1:0] wdata, rdata, cmp_src;
   logic [2:0] rd_row;
   logic last_orient, row_match;

   tdfm_ram #(.Width(RowW), .Depth(StoreDepth)) u_store (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   // The compare is on the row read in the previous cycle (stored row rd_row) against gathered row r_ff.
   assign rd_row = orient_ff[1] ? 3'(Rows - 1) - r_ff : r_ff;
   assign cmp_src = orient_ff[0] ? mirror_row(rdata) : rdata;
   assign row_match = ok_ff && (cmp_src == rows_ff[r_ff]);
   assign last_orient = flip_disable || (orient_ff == 2'd3);
   assign wdata = rows_ff[r_ff];

   always_comb begin
      we = 1'b0;
      addr = {tile_ff, rd_row};
      case (state_ff)
         ST_WRITE: begin
            we = 1'b1;
            addr = {count_ff[TileIdxW-1:0], r_ff};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      rowcnt_in = rowcnt_ff;
      count_in = count_ff;
      tile_in = tile_ff;
      orient_in = orient_ff;
      r_in = r_ff;
      ok_in = ok_ff;
      res_in = res_ff;
      case (state_ff)
         ST_GATHER: begin
            if (row_valid) begin
               rowcnt_in = rowcnt_ff + 3'd1;
               if (rowcnt_ff == 3'(Rows - 1)) begin
                  tile_in = '0;
                  orient_in = '0;
                  r_in = '0;
                  ok_in = 1'b1;
                  state_in = (count_ff == '0) ? ST_WRITE : ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            ok_in = row_match;
            if (r_ff == 3'(Rows - 1)) begin
               r_in = '0;
               ok_in = 1'b1;
               if (row_match) begin
                  res_in = '0;
                  res_in.tile_index = OutIdxW'(tile_ff);
                  res_in.hflip = orient_ff[0];
                  res_in.vflip = orient_ff[1];
                  res_in.tile_palette = pal_ff;
                  state_in = ST_OUT;
               end else if (!last_orient) begin
                  orient_in = orient_ff + 2'd1;
                  state_in = ST_READ;
               end else begin
                  orient_in = '0;
                  if (CountW'(tile_ff) + CountW'(1) == count_ff) begin
                     if (count_ff == CountW'(MaxTiles)) begin
                        res_in = '0;
                        res_in.store_full = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end else begin
                     tile_in = tile_ff + TileIdxW'(1);
                     state_in = ST_READ;
                  end
               end
            end else begin
               r_in = r_ff + 3'd1;
               state_in = ST_READ;
            end
         end
         ST_WRITE: begin
            r_in = r_ff + 3'd1;
            if (r_ff == 3'(Rows - 1)) begin
               res_in = '0;
               res_in.tile_index = OutIdxW'(count_ff);
               res_in.new_tile = 1'b1;
               res_in.tile_palette = pal_ff;
               count_in = count_ff + CountW'(1);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (res_ready) begin
               state_in = ST_GATHER;
            end
         end
         default: state_in = ST_GATHER;
      endcase
   end

   assign row_ready = (state_ff == ST_GATHER);
   assign res_valid = (state_ff == ST_OUT);
   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_GATHER;
         rowcnt_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         rowcnt_ff <= rowcnt_in;
         count_ff <= count_in;
      end
      tile_ff <= tile_in;
      orient_ff <= orient_in;
      r_ff <= r_in;
      ok_ff <= ok_in;
      res_ff <= res_in;
      if (row_valid && row_ready) begin
         rows_ff[rowcnt_ff] <= row_pixels;
         pal_ff <= palette_line;
      end
   end
endmodule
